[rtl/pf_pkg.sv]
// Shared types, constants and helpers for the Playfair digraph cipher.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package pf_pkg;

  localparam int GRID  = 5;
  localparam int CELLS = GRID * GRID;

  localparam int CODE_W   = 5;   // letter code, A=0
  localparam int COORD_W  = 3;   // row or column, 0..4
  localparam int LETTER_W = 7;   // ASCII letter
  localparam int CHAR_W   = 8;
  localparam int WIDE_W   = 60;  // twelve cells per wide register
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_LAST = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT     = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

  localparam logic [CODE_W-1:0] CODE_I = 5'd8;
  localparam logic [CODE_W-1:0] CODE_J = 5'd9;
  localparam logic [CODE_W-1:0] CODE_Z = 5'd25;

  localparam logic [LETTER_W-1:0] LETTER_A = 7'h41;
  localparam logic [LETTER_W-1:0] LETTER_Z = 7'h5A;

  localparam logic [COORD_W-1:0] COORD_MAX = 3'(GRID - 1);

  typedef logic [CELLS-1:0][CODE_W-1:0] square_t;

  // a pair waiting to be enciphered, or a bare end marker
  typedef struct packed {
    logic              bare;
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] second;
    logic              last;
  } pair_req_t;

  // a finished output pair
  typedef struct packed {
    logic                bare;
    logic [LETTER_W-1:0] letter0;
    logic [LETTER_W-1:0] letter1;
    logic                last;
  } out_job_t;

  // one step around the ring of rows or columns, forward or back
  function automatic logic [COORD_W-1:0] wrap_step(input logic [COORD_W-1:0] v,
                                                   input logic back);
    logic [COORD_W-1:0] res;
    if (back) begin
      res = (v == '0) ? COORD_MAX : v - 3'd1;
    end else begin
      res = (v == COORD_MAX) ? '0 : v + 3'd1;
    end
    return res;
  endfunction

  // row * 5 + col
  function automatic logic [CODE_W-1:0] cell_index(input logic [COORD_W-1:0] row,
                                                   input logic [COORD_W-1:0] col);
    return {row, 2'b00} + CODE_W'(row) + CODE_W'(col);
  endfunction

  // unused codes print as Z
  function automatic logic [LETTER_W-1:0] code_letter(input logic [CODE_W-1:0] code);
    logic [LETTER_W-1:0] res;
    if (code > CODE_Z) begin
      res = LETTER_Z;
    end else begin
      res = LETTER_A + LETTER_W'(code);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/pf_locate.sv]
// Finds the first key-square cell holding a letter code; row/column out.
// Depends on pf_pkg.
`default_nettype none

module pf_locate
  import pf_pkg::*;
(
  input  wire square_t            square,
  input  wire logic [CODE_W-1:0]  code,
  output logic      [COORD_W-1:0] row,
  output logic      [COORD_W-1:0] col
);

  // scan from the top so the lowest matching cell wins; no match -> cell 0
  always_comb begin
    row = '0;
    col = '0;
    for (int k = CELLS - 1; k >= 0; k--) begin
      if (square[k] == code) begin
        row = COORD_W'(k / GRID);
        col = COORD_W'(k % GRID);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/pf_xform.sv]
// Digraph transform: locates both letters and applies row/column/rectangle rules.
// Depends on pf_pkg and pf_locate.
`default_nettype none

module pf_xform
  import pf_pkg::*;
(
  input  wire square_t   square,
  input  wire logic      decrypt,
  input  wire pair_req_t req,
  output out_job_t       job
);

  logic [COORD_W-1:0] r1, c1, r2, c2;
  logic [COORD_W-1:0] xr, xc, yr, yc;
  logic [CODE_W-1:0]  x_idx, y_idx;

  pf_locate u_loc_a (.square(square), .code(req.first),  .row(r1), .col(c1));
  pf_locate u_loc_b (.square(square), .code(req.second), .row(r2), .col(c2));

  always_comb begin
    if (r1 == r2) begin
      xr = r1;
      yr = r2;
      xc = wrap_step(c1, decrypt);
      yc = wrap_step(c2, decrypt);
    end else if (c1 == c2) begin
      xr = wrap_step(r1, decrypt);
      yr = wrap_step(r2, decrypt);
      xc = c1;
      yc = c2;
    end else begin
      // rectangle: swap columns
      xr = r1;
      yr = r2;
      xc = c2;
      yc = c1;
    end
  end

  assign x_idx = cell_index(xr, xc);
  assign y_idx = cell_index(yr, yc);

  always_comb begin
    job.bare    = req.bare;
    job.letter0 = code_letter(square[x_idx]);
    job.letter1 = code_letter(square[y_idx]);
    job.last    = req.last;
  end

endmodule

`default_nettype wire

[rtl/pf_front.sv]
// Input front end: letter decode, pairing state and the pair request register.
// Depends on pf_pkg.
`default_nettype none

module pf_front
  import pf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CHAR_W-1:0] in_char,
  input  wire logic              in_message_last,
  input  wire logic              req_take,
  output logic                   req_valid,
  output pair_req_t              req
);

  logic              is_letter;
  logic [CODE_W-1:0] code;
  logic              accept;
  logic              emit;
  pair_req_t         new_req;

  logic              holding_r, holding_nxt;
  logic [CODE_W-1:0] held_r, held_nxt;
  logic              req_valid_r, req_valid_nxt;
  pair_req_t         req_r, req_nxt;

  always_comb begin
    is_letter = 1'b0;
    code      = '0;
    if (in_char inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      is_letter = 1'b1;
      code      = CODE_W'(in_char - CHAR_UPPER_A);
    end else if (in_char inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
      is_letter = 1'b1;
      code      = CODE_W'(in_char - CHAR_LOWER_A);
    end
    if (code == CODE_J) begin
      code = CODE_I;
    end
  end

  assign in_ready = !req_valid_r || req_take;
  assign accept   = in_valid && in_ready;

  // pairing decisions
  always_comb begin
    emit         = 1'b0;
    holding_nxt  = holding_r;
    held_nxt     = held_r;
    new_req      = '0;
    new_req.last = in_message_last;
    if (is_letter) begin
      if (holding_r) begin
        emit           = 1'b1;
        holding_nxt    = 1'b0;
        new_req.first  = held_r;
        new_req.second = code;
      end else if (in_message_last) begin
        emit           = 1'b1;
        new_req.first  = code;
        new_req.second = CODE_Z;
      end else begin
        holding_nxt = 1'b1;
        held_nxt    = code;
      end
    end else if (in_message_last) begin
      emit = 1'b1;
      if (holding_r) begin
        holding_nxt    = 1'b0;
        new_req.first  = held_r;
        new_req.second = CODE_Z;
      end else begin
        new_req.bare = 1'b1;
      end
    end
  end

  always_comb begin
    req_valid_nxt = req_valid_r;
    req_nxt       = req_r;
    if (accept && emit) begin
      req_valid_nxt = 1'b1;
      req_nxt       = new_req;
    end else if (req_take) begin
      req_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holding_r   <= 1'b0;
      held_r      <= '0;
      req_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        holding_r <= holding_nxt;
        held_r    <= held_nxt;
      end
      req_valid_r <= req_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  assign req_valid = req_valid_r;
  assign req       = req_r;

endmodule

`default_nettype wire

[rtl/playfair_digraph_cipher.sv]
// Playfair 5x5 digraph cipher, top level.
// Depends on pf_pkg, pf_front, pf_xform (which uses pf_locate).
//
// Usage:
//  - Input channel (in_valid/in_ready): one raw byte per transaction plus
//    in_message_last. Non-letters are dropped; letters are upper-cased, J->I,
//    and paired in arrival order.
//  - Output channel (out_valid/out_ready): one letter per transaction. A pair
//    gives two transactions (second flagged by out_second_of_pair). At message
//    end a lone letter is padded with Z; with nothing held a bare end marker
//    (out_letter_valid = 0, out_message_end = 1) is sent.
//  - Config channel (cfg_valid/cfg_ready, always ready): cfg_index selects
//    square_low, square_mid, square_last or decrypt_mode. Write only while idle.
//  - Path: a byte that completes a pair passes the pair request register, then
//    the output register, which shows its first letter.
//  - Throughput: one input transaction per cycle while in_ready is high; a completed
//    pair holds the output register for two output transactions, so sustained rate is
//    set by the output port at one letter per cycle (about one input per cycle).
//  - Reset (rst_n low, synchronous): no letter held, both stages empty,
//    square and mode cleared to zero.
//  - Receiver stall: the output register holds; the pair request register
//    fills next, then in_ready drops for every byte, even one that is only held.
`default_nettype none

module playfair_digraph_cipher
  import pf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WIDE_W-1:0]    cfg_data,
  // input bytes
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CHAR_W-1:0]    in_char,
  input  wire logic                 in_message_last,
  // output letters
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [LETTER_W-1:0]       out_letter,
  output logic                      out_letter_valid,
  output logic                      out_second_of_pair,
  output logic                      out_message_end
);

  // configuration registers
  logic [WIDE_W-1:0] sq_low_r, sq_mid_r;
  logic [CODE_W-1:0] sq_last_r;
  logic              decrypt_r;
  square_t           square;

  // pipeline
  logic      req_valid;
  pair_req_t req;
  out_job_t  job;
  logic      ob_load, ob_done;

  logic      ob_valid_r, ob_valid_nxt;
  logic      ob_phase_r, ob_phase_nxt;
  out_job_t  ob_job_r, ob_job_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_low_r  <= '0;
      sq_mid_r  <= '0;
      sq_last_r <= '0;
      decrypt_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SQUARE_LOW:  sq_low_r  <= cfg_data;
        CFG_SQUARE_MID:  sq_mid_r  <= cfg_data;
        CFG_SQUARE_LAST: sq_last_r <= cfg_data[CODE_W-1:0];
        CFG_DECRYPT:     decrypt_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // unpack the 25 cells, cell k at row k/5, column k%5
  always_comb begin
    for (int k = 0; k < 12; k++) begin
      square[k]      = sq_low_r[k*CODE_W +: CODE_W];
      square[k + 12] = sq_mid_r[k*CODE_W +: CODE_W];
    end
    square[CELLS-1] = sq_last_r;
  end

  pf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char         (in_char),
    .in_message_last (in_message_last),
    .req_take        (ob_load),
    .req_valid       (req_valid),
    .req             (req)
  );

  pf_xform u_xform (
    .square  (square),
    .decrypt (decrypt_r),
    .req     (req),
    .job     (job)
  );

  // output register: one job, shown as one (bare) or two letter transactions
  assign ob_done = ob_valid_r && out_ready && (ob_job_r.bare || ob_phase_r);
  assign ob_load = req_valid && (!ob_valid_r || ob_done);

  always_comb begin
    ob_valid_nxt = ob_valid_r;
    ob_phase_nxt = ob_phase_r;
    ob_job_nxt   = ob_job_r;
    if (ob_load) begin
      ob_valid_nxt = 1'b1;
      ob_phase_nxt = 1'b0;
      ob_job_nxt   = job;
    end else if (ob_done) begin
      ob_valid_nxt = 1'b0;
      ob_phase_nxt = 1'b0;
    end else if (ob_valid_r && out_ready) begin
      ob_phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_valid_r <= 1'b0;
      ob_phase_r <= 1'b0;
    end else begin
      ob_valid_r <= ob_valid_nxt;
      ob_phase_r <= ob_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_job_r <= ob_job_nxt;
  end

  assign out_valid          = ob_valid_r;
  assign out_letter         = ob_job_r.bare ? '0 :
                              (ob_phase_r ? ob_job_r.letter1 : ob_job_r.letter0);
  assign out_letter_valid   = !ob_job_r.bare;
  assign out_second_of_pair = ob_phase_r;
  assign out_message_end    = ob_job_r.bare || (ob_phase_r && ob_job_r.last);

endmodule

`default_nettype wire

[dv/tb_playfair_digraph_cipher.sv]
// Self-checking testbench for playfair_digraph_cipher: a directed table, then random messages.
// It compares every output transaction with an expected queue, filled by its predictor or the directed table.
// Depends on pf_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_playfair_digraph_cipher;
  import pf_pkg::*;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 250;   // letters and end bytes per random phase
  localparam int DRAIN_CYCLES = 8;     // pipeline is two stages deep
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 3000;
  localparam int MAX_REPORTS  = 40;
  localparam int CELLS_PER_REG = 12;
  localparam logic [CODE_W-1:0] CODE_MAX = 5'h1F;

  // one output transaction
  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                letter_valid;
    logic                second;
    logic                msg_end;
  } letter_rec_t;

  typedef enum logic [1:0] {SQ_KEEP, SQ_ONES, SQ_CLASSIC_ENC, SQ_CLASSIC_DEC} square_setup_t;
  // ROW_MODEL rows are checked against the predictor; the others carry their answer
  typedef enum logic [1:0] {ROW_MODEL, ROW_QUIET, ROW_PAIR, ROW_MARKER} row_kind_t;
  typedef enum logic [1:0] {SINK_FREE, SINK_COIN, SINK_SLOW, SINK_TOGGLE} sink_mode_t;

  typedef struct packed {
    square_setup_t       setup;
    logic [CHAR_W-1:0]   ch;
    logic                last;
    row_kind_t           kind;
    logic [LETTER_W-1:0] l0;
    logic [LETTER_W-1:0] l1;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 25;

  stim_row_t plan [DIRECTED_ROWS] = '{
    // reset square: every cell holds A, so every letter lands in cell 0
    '{SQ_KEEP,        "A",   1'b0, ROW_QUIET,  '0,       '0},
    '{SQ_KEEP,        "z",   1'b0, ROW_PAIR,   LETTER_A, LETTER_A},
    '{SQ_KEEP,        8'h00, 1'b0, ROW_QUIET,  '0,       '0},
    '{SQ_KEEP,        8'hFF, 1'b1, ROW_MARKER, '0,       '0},   // end, nothing held
    '{SQ_KEEP,        "J",   1'b1, ROW_PAIR,   LETTER_A, LETTER_A}, // lone letter, Z pad
    '{SQ_KEEP,        "@",   1'b0, ROW_QUIET,  '0,       '0},
    '{SQ_KEEP,        "[",   1'b0, ROW_QUIET,  '0,       '0},
    '{SQ_KEEP,        "{",   1'b0, ROW_QUIET,  '0,       '0},
    '{SQ_KEEP,        "a",   1'b0, ROW_QUIET,  '0,       '0},
    '{SQ_KEEP,        "~",   1'b1, ROW_PAIR,   LETTER_A, LETTER_A}, // end on a non-letter
    // all cells unused codes except Z in the last cell
    '{SQ_ONES,        "Q",   1'b0, ROW_QUIET,  '0,       '0},
    '{SQ_KEEP,        "q",   1'b0, ROW_PAIR,   LETTER_Z, LETTER_Z},
    '{SQ_KEEP,        "B",   1'b1, ROW_PAIR,   LETTER_Z, LETTER_Z},
    // textbook square, rectangle / column / row / doubled / J
    '{SQ_CLASSIC_ENC, "h",   1'b0, ROW_MODEL,  '0,       '0},
    '{SQ_KEEP,        "i",   1'b0, ROW_MODEL,  '0,       '0},
    '{SQ_KEEP,        "d",   1'b0, ROW_MODEL,  '0,       '0},
    '{SQ_KEEP,        "e",   1'b0, ROW_MODEL,  '0,       '0},
    '{SQ_KEEP,        "E",   1'b0, ROW_MODEL,  '0,       '0},
    '{SQ_KEEP,        "x",   1'b0, ROW_MODEL,  '0,       '0},
    '{SQ_KEEP,        "o",   1'b0, ROW_MODEL,  '0,       '0},
    '{SQ_KEEP,        "o",   1'b0, ROW_MODEL,  '0,       '0},
    '{SQ_KEEP,        "j",   1'b1, ROW_MODEL,  '0,       '0},
    '{SQ_CLASSIC_DEC, "B",   1'b0, ROW_MODEL,  '0,       '0},
    '{SQ_KEEP,        "M",   1'b0, ROW_MODEL,  '0,       '0},
    '{SQ_KEEP,        "K",   1'b1, ROW_MODEL,  '0,       '0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WIDE_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CHAR_W-1:0]   in_char = '0;
  logic                in_message_last = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [LETTER_W-1:0] out_letter;
  logic                out_letter_valid;
  logic                out_second_of_pair;
  logic                out_message_end;

  playfair_digraph_cipher u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char           (in_char),
    .in_message_last   (in_message_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_letter        (out_letter),
    .out_letter_valid  (out_letter_valid),
    .out_second_of_pair(out_second_of_pair),
    .out_message_end   (out_message_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state, mirrors the block
  logic [CODE_W-1:0] key_cell [CELLS];
  logic [CODE_W-1:0] stage_cell [CELLS];
  bit                deciphering = 1'b0;
  logic [CODE_W-1:0] held_code = '0;
  bit                letter_held = 1'b0;

  letter_rec_t letters_due[$];   // expected output, oldest first
  letter_rec_t fresh[$];         // letters caused by the latest byte

  int  mismatches = 0;
  int  letters_checked = 0;
  int  bytes_sent = 0;
  int  messages_sent = 0;
  int  cfg_writes = 0;
  int  holds_done = 0;
  int  burst_left = 0;
  bit  hold_request = 1'b0;

  task automatic note_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // first cell holding the code, cell 0 if none does
  function automatic int locate_code(input logic [CODE_W-1:0] code);
    for (int k = 0; k < CELLS; k++)
      if (key_cell[k] == code) return k;
    return 0;
  endfunction

  function automatic logic [LETTER_W-1:0] glyph_of(input int k);
    if (key_cell[k] > CODE_Z) return LETTER_Z;
    return LETTER_A + LETTER_W'(key_cell[k]);
  endfunction

  function automatic void cipher_pair(input logic [CODE_W-1:0] a, input logic [CODE_W-1:0] b,
                                      input bit ends);
    int p, q, r1, c1, r2, c2, s, x, y;
    p  = locate_code(a);
    q  = locate_code(b);
    r1 = p / GRID;
    c1 = p % GRID;
    r2 = q / GRID;
    c2 = q % GRID;
    s  = deciphering ? GRID - 1 : 1;
    if (r1 == r2) begin
      x = r1 * GRID + (c1 + s) % GRID;
      y = r2 * GRID + (c2 + s) % GRID;
    end else if (c1 == c2) begin
      x = ((r1 + s) % GRID) * GRID + c1;
      y = ((r2 + s) % GRID) * GRID + c2;
    end else begin
      x = r1 * GRID + c2;
      y = r2 * GRID + c1;
    end
    fresh.push_back(letter_rec_t'{glyph_of(x), 1'b1, 1'b0, 1'b0});
    fresh.push_back(letter_rec_t'{glyph_of(y), 1'b1, 1'b1, ends});
  endfunction

  function automatic void absorb_byte(input logic [CHAR_W-1:0] ch, input bit last);
    bit                is_letter;
    logic [CODE_W-1:0] code;
    is_letter = 1'b0;
    code = '0;
    if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
      is_letter = 1'b1;
      code = CODE_W'(ch - CHAR_UPPER_A);
    end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
      is_letter = 1'b1;
      code = CODE_W'(ch - CHAR_LOWER_A);
    end
    if (code == CODE_J) code = CODE_I;
    if (is_letter) begin
      if (letter_held) begin
        letter_held = 1'b0;
        cipher_pair(held_code, code, last);
      end else if (last) begin
        cipher_pair(code, CODE_Z, 1'b1);
      end else begin
        held_code = code;
        letter_held = 1'b1;
      end
    end else if (last) begin
      if (letter_held) begin
        letter_held = 1'b0;
        cipher_pair(held_code, CODE_Z, 1'b1);
      end else begin
        fresh.push_back(letter_rec_t'{'0, 1'b0, 1'b0, 1'b1});
      end
    end
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [WIDE_W-1:0] data);
    case (idx)
      CFG_SQUARE_LOW: begin
        for (int k = 0; k < CELLS_PER_REG; k++) key_cell[k] = data[CODE_W*k +: CODE_W];
      end
      CFG_SQUARE_MID: begin
        for (int k = 0; k < CELLS_PER_REG; k++)
          key_cell[CELLS_PER_REG + k] = data[CODE_W*k +: CODE_W];
      end
      CFG_SQUARE_LAST: key_cell[CELLS-1] = data[CODE_W-1:0];
      default:         deciphering = data[0];
    endcase
  endfunction

  // key square candidates, built in stage_cell before loading
  function automatic void stage_fill(input logic [CODE_W-1:0] v);
    for (int k = 0; k < CELLS; k++) stage_cell[k] = v;
  endfunction

  function automatic void stage_ones();
    stage_fill(CODE_MAX);
    stage_cell[CELLS-1] = CODE_Z;
  endfunction

  function automatic void stage_classic();
    string key;
    key = "PLAYFIREXMBCDGHKNOQSTUVWZ";
    for (int k = 0; k < CELLS; k++) stage_cell[k] = CODE_W'(key[k] - CHAR_UPPER_A);
  endfunction

  // random permutation of the 25 letters without J
  function automatic void stage_shuffle();
    int                n, j;
    logic [CODE_W-1:0] t;
    n = 0;
    for (int c = 0; c <= CODE_Z; c++) begin
      if (CODE_W'(c) != CODE_J) begin
        stage_cell[n] = CODE_W'(c);
        n++;
      end
    end
    for (int k = CELLS - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = stage_cell[k];
      stage_cell[k] = stage_cell[j];
      stage_cell[j] = t;
    end
  endfunction

  // arbitrary codes: duplicates, missing letters, unused codes
  function automatic void stage_noise();
    for (int k = 0; k < CELLS - 1; k++) stage_cell[k] = CODE_W'($urandom_range(0, 31));
    stage_cell[CELLS-1] = CODE_W'($urandom_range(0, CODE_Z));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIDE_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_cfg(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_stage(input bit dec);
    logic [WIDE_W-1:0] lo, mid;
    lo  = '0;
    mid = '0;
    for (int k = 0; k < CELLS_PER_REG; k++) begin
      lo[CODE_W*k +: CODE_W]  = stage_cell[k];
      mid[CODE_W*k +: CODE_W] = stage_cell[CELLS_PER_REG + k];
    end
    write_reg(CFG_SQUARE_LOW, lo);
    write_reg(CFG_SQUARE_MID, mid);
    write_reg(CFG_SQUARE_LAST, WIDE_W'(stage_cell[CELLS-1]));
    write_reg(CFG_DECRYPT, WIDE_W'(dec));
  endtask

  // stop offering, let every expected letter arrive, then let the pipe settle
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (letters_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one input transaction; predicted letters are queued when use_model is set
  task automatic send_byte(input logic [CHAR_W-1:0] ch, input bit last, input bit use_model);
    @(negedge clk);
    in_valid        <= 1'b1;
    in_char         <= ch;
    in_message_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fresh.delete();
    absorb_byte(ch, last);
    if (use_model) foreach (fresh[i]) letters_due.push_back(fresh[i]);
    bytes_sent++;
    if (last) messages_sent++;
  endtask

  // bursts of back-to-back bytes with random gaps; some bursts are long
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 16);
    end
  endtask

  // receiver: random segments of stall patterns, plus long hold-offs on request
  initial begin : sink
    sink_mode_t mode;
    int         seg_left, hold_left;
    mode = SINK_FREE;
    seg_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = sink_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(8, 120);
        end
        seg_left--;
        case (mode)
          SINK_FREE: out_ready <= 1'b1;
          SINK_COIN: out_ready <= 1'($urandom_range(0, 1));
          SINK_SLOW: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // compare each output transaction with the oldest expectation
  always @(posedge clk) begin : scoreboard
    letter_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (letters_due.size() == 0) begin
        note_mismatch($sformatf("unexpected output, letter %h end %b",
                                out_letter, out_message_end));
      end else begin
        want = letters_due.pop_front();
        if (out_letter !== want.letter)
          note_mismatch($sformatf("#%0d out_letter %h, expected %h",
                                  letters_checked, out_letter, want.letter));
        if (out_letter_valid !== want.letter_valid)
          note_mismatch($sformatf("#%0d out_letter_valid %b, expected %b",
                                  letters_checked, out_letter_valid, want.letter_valid));
        if (out_second_of_pair !== want.second)
          note_mismatch($sformatf("#%0d out_second_of_pair %b, expected %b",
                                  letters_checked, out_second_of_pair, want.second));
        if (out_message_end !== want.msg_end)
          note_mismatch($sformatf("#%0d out_message_end %b, expected %b",
                                  letters_checked, out_message_end, want.msg_end));
      end
      letters_checked++;
    end
  end

  // ends the run when no channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: %0d cycles without a transaction", quiet);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int                counted, len, roll;
    bit                dec, last;
    logic [CHAR_W-1:0] ch;
    logic [CODE_W-1:0] code, prev_code;
    prev_code = '0;
    for (int k = 0; k < CELLS; k++) key_cell[k] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (plan[i]) begin
      if (plan[i].setup != SQ_KEEP) begin
        drain_pipeline();
        case (plan[i].setup)
          SQ_ONES: begin
            stage_ones();
            load_stage(1'b0);
          end
          SQ_CLASSIC_ENC: begin
            stage_classic();
            load_stage(1'b0);
          end
          default: begin
            stage_classic();
            load_stage(1'b1);
          end
        endcase
      end
      send_byte(plan[i].ch, plan[i].last, plan[i].kind == ROW_MODEL);
      case (plan[i].kind)
        ROW_PAIR: begin
          letters_due.push_back(letter_rec_t'{plan[i].l0, 1'b1, 1'b0, 1'b0});
          letters_due.push_back(letter_rec_t'{plan[i].l1, 1'b1, 1'b1, plan[i].last});
        end
        ROW_MARKER: letters_due.push_back(letter_rec_t'{'0, 1'b0, 1'b0, 1'b1});
        default: ;
      endcase
      pace_sender();
    end

    // random messages, a fresh key square per phase
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_pipeline();
      case (phase)
        0: begin
          stage_fill('0);
          dec = 1'b1;
        end
        1: begin
          stage_ones();
          dec = 1'b0;
        end
        default: begin
          if ($urandom_range(0, 3) == 0) stage_noise();
          else stage_shuffle();
          dec = 1'($urandom_range(0, 1));
        end
      endcase
      load_stage(dec);
      if (phase == 2 || phase == 5) hold_request = 1'b1;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        len = $urandom_range(0, 24);
        for (int n = 0; n <= len; n++) begin
          last = (n == len);
          roll = $urandom_range(0, 99);
          if (roll < 12) begin
            ch = CHAR_W'($urandom_range(0, 255));
          end else begin
            if (roll < 20) code = CODE_J;
            else if (roll < 32) code = prev_code;   // doubled letters
            else code = CODE_W'($urandom_range(0, CODE_Z));
            ch = ($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(code);
            prev_code = code;
          end
          send_byte(ch, last, 1'b1);
          pace_sender();
          if (last || (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ||
              (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z))
            counted++;
        end
      end
    end

    drain_pipeline();
    if (letters_due.size() != 0)
      note_mismatch($sformatf("%0d expected letters never arrived", letters_due.size()));

    $display("covered %0d bytes in %0d messages, %0d output transactions checked",
             bytes_sent, messages_sent, letters_checked);
    $display("%0d register writes over %0d key squares, %0d long receiver hold-offs",
             cfg_writes, PHASES + 3, holds_done);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
